### hw/rtl/athg_pkg.sv
// athg_pkg: shared types, constants and helpers for the audio-to-haptics generator.
// No dependencies.
`timescale 1ns / 1ps
package athg_pkg;

  localparam int SAMPLE_W = 16;
  localparam int ACC_W    = 48;

  localparam logic signed [ACC_W-1:0] ONE_Q30 = 48'sd1073741824;
  localparam logic [31:0] ATTACK_Q30  = 32'd429496730;
  localparam logic [31:0] RELEASE_Q30 = 32'd26843546;
  localparam logic [8:0]  QUIET_PEAK = 9'd256;
  localparam logic [18:0] GAIN_DIV = 19'd409600;

  typedef enum logic [1:0] {
    MODE_OFF      = 2'd0,
    MODE_FALLBACK = 2'd1,
    MODE_MIX      = 2'd2,
    MODE_REPLACE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_AUTO_MODE   = 2'd0,
    REG_HAPTIC_GAIN = 2'd1,
    REG_AUTO_GAIN   = 2'd2,
    REG_LOWPASS_SEL = 2'd3
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LP,
    ST_ENV,
    ST_SHAPE,
    ST_GAIN,
    ST_GDIV,
    ST_CLIP,
    ST_MIXCLIP,
    ST_NEXTCH,
    ST_OUT
  } state_t;

  function automatic logic [31:0] lowpass_coef(input logic [1:0] sel);
    logic [31:0] c;
    unique case (sel)
      2'd0: c = 32'd11156178;
      2'd1: c = 32'd22269405;
      2'd2: c = 32'd33232309;
      default: c = 32'd55007794;
    endcase
    return c;
  endfunction

endpackage

### hw/rtl/athg_if.sv
// athg_if: valid/ready stream interfaces for input samples and haptic results.
// Depends on athg_pkg for widths.
`timescale 1ns / 1ps
interface athg_in_if;
  import athg_pkg::*;
  logic valid;
  logic ready;
  logic signed [SAMPLE_W-1:0] speaker_left;
  logic signed [SAMPLE_W-1:0] speaker_right;
  logic signed [SAMPLE_W-1:0] native_left;
  logic signed [SAMPLE_W-1:0] native_right;
  logic packet_end;
  modport source (output valid, speaker_left, speaker_right, native_left, native_right,
                  packet_end, input ready);
  modport sink (input valid, speaker_left, speaker_right, native_left, native_right,
                packet_end, output ready);
endinterface

interface athg_out_if;
  import athg_pkg::*;
  logic valid;
  logic ready;
  logic signed [SAMPLE_W-1:0] haptic_out_left;
  logic signed [SAMPLE_W-1:0] haptic_out_right;
  modport source (output valid, haptic_out_left, haptic_out_right, input ready);
  modport sink (input valid, haptic_out_left, haptic_out_right, output ready);
endinterface

### hw/rtl/athg_serial_mul.sv
// athg_serial_mul: shift-add multiplier, one multiplier bit per cycle, with
// round-half-up shift right by a constant. Depends on athg_pkg.
`timescale 1ns / 1ps
module athg_serial_mul #(
  parameter int AW = 48,
  parameter int BW = 32,
  parameter int SH = 30
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [AW-1:0] a,
  input  logic [BW-1:0]        b,
  output logic                 done,
  output logic signed [AW+BW-1:0] product,
  output logic signed [AW+BW-1:0] rounded
);
  import athg_pkg::*;
  localparam int CW = $clog2(BW + 1);
  localparam int PW = AW + BW;

  logic signed [PW-1:0] acc;
  logic signed [PW-1:0] mcand;
  logic [BW-1:0] mplier;
  logic [CW-1:0] count;
  logic busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= CW'(BW);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      mcand <= PW'(a);
      mplier <= b;
    end else if (busy) begin
      if (mplier[0]) acc <= acc + mcand;
      mcand <= mcand <<< 1;
      mplier <= mplier >> 1;
    end
  end

  assign product = acc;
  assign rounded = (acc + (PW'(1) <<< (SH - 1))) >>> SH;
endmodule

### hw/rtl/athg_serial_div.sv
// athg_serial_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on athg_pkg.
`timescale 1ns / 1ps
module athg_serial_div #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quot
);
  import athg_pkg::*;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0] rem;
  logic [W-1:0] q;
  logic [W-1:0] d;
  logic [CW-1:0] count;
  logic busy;
  logic [W:0] trial;

  assign trial = {rem, q[W-1]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= CW'(W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q <= num;
      d <= den;
    end else if (busy) begin
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        q <= {q[W-2:0], 1'b1};
      end else begin
        rem <= {rem[W-2:0], q[W-1]};
        q <= {q[W-2:0], 1'b0};
      end
    end
  end

  assign quot = q;
endmodule

### hw/rtl/audio_to_haptics_generator.sv
// audio_to_haptics_generator: top level of the audio-to-haptics generator.
// Depends on athg_pkg, athg_if, athg_serial_mul and athg_serial_div.
`timescale 1ns / 1ps
// Usage: one input transaction carries a four-channel sample (two speaker
// and two native haptic channels, Q1.15) plus a packet-end flag. Each
// accepted transaction yields exactly one output transaction with the
// left and right haptic drive in Q1.15.
// All wide arithmetic runs on one shift-add multiplier (one multiplier bit
// per cycle) and one restoring divider (one quotient bit per cycle), shared
// by both channels. Each channel takes four products, two quotients (three
// in mix mode) and a store step for its result; with the generator off, the
// channel steps are skipped. The block takes no new input transaction until
// the current sample's result is in the output register; it is ready again
// in the same cycle as that result becomes valid.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Reset restores register defaults, clears filter and envelope state, and
// sets the silence counter to twice the timeout with fallback active.
// If the receiver stalls, the result waits in the output register while the
// next sample is accepted and computed; that result then waits in the core,
// and no further input transaction is accepted until the output is taken.
module audio_to_haptics_generator #(
  parameter int SILENCE_TIMEOUT = 100
) (
  input  logic clk,
  input  logic rst,
  athg_in_if.sink in_ch,
  athg_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import athg_pkg::*;
  localparam int SCW = $clog2(2 * SILENCE_TIMEOUT + 1);
  localparam logic [SCW-1:0] SIL_MAX = SCW'(2 * SILENCE_TIMEOUT);
  localparam logic [SCW-1:0] SIL_TO  = SCW'(SILENCE_TIMEOUT);

  // Configuration registers.
  mode_t gen_mode;
  logic [15:0] haptic_gain;
  logic [7:0] auto_gain_percent;
  logic [1:0] lowpass_select;

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_mode <= MODE_FALLBACK;
      haptic_gain <= 16'd4096;
      auto_gain_percent <= 8'd100;
      lowpass_select <= 2'd0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_AUTO_MODE:   gen_mode <= mode_t'(cfg_data[1:0]);
        REG_HAPTIC_GAIN: haptic_gain <= cfg_data;
        REG_AUTO_GAIN:   auto_gain_percent <= cfg_data[7:0];
        REG_LOWPASS_SEL: lowpass_select <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Filter state in Q.30; lowpass stays within +-1, envelope within [0,1].
  logic signed [ACC_W-1:0] lp [2];
  logic signed [ACC_W-1:0] env [2];
  logic [SCW-1:0] silence_count;
  logic [15:0] packet_peak;
  logic fallback_flag;

  // Latched sample.
  logic signed [15:0] spk [2];
  logic signed [15:0] nat [2];
  logic pend;
  logic ch;
  logic use_gen;
  logic signed [15:0] work_res [2];
  logic signed [15:0] res [2];
  logic out_valid;
  logic out_free;

  state_t state, state_next;

  // Shared multiplier: 48-bit signed operand times 32-bit unsigned operand.
  logic mul_start, mul_done;
  logic signed [ACC_W-1:0] mul_a;
  logic [31:0] mul_b;
  logic signed [79:0] mul_prod, mul_rnd;
  athg_serial_mul #(.AW(ACC_W), .BW(32), .SH(30)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .product(mul_prod), .rounded(mul_rnd)
  );

  logic div_start, div_done;
  logic [63:0] div_num, div_den, div_q;
  athg_serial_div #(.W(64)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_q)
  );

  // Working registers for the current channel.
  logic signed [ACC_W-1:0] t_val;   // shaped value, then gained value, then clipped value
  logic signed [ACC_W-1:0] g_val;   // generated value after soft clip, or the clipped mix in mix mode
  logic neg;
  logic started;

  // Per-channel native scaled value, Q.30: n * gain * 8 fits 35 bits.
  logic signed [ACC_W-1:0] hn;
  assign hn = ACC_W'($signed(nat[ch]) * $signed({1'b0, haptic_gain})) <<< 3;

  function automatic logic signed [15:0] to_q15(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    logic signed [ACC_W-1:0] r;
    c = v;
    if (c > ONE_Q30) c = ONE_Q30;
    if (c < -ONE_Q30) c = -ONE_Q30;
    r = (c + ACC_W'(16384)) >>> 15;
    if (r > ACC_W'(32767)) r = ACC_W'(32767);
    return r[15:0];
  endfunction

  logic signed [ACC_W-1:0] lp_diff, env_mag, env_diff, mix_sum, mix_mag, gen_abs;
  assign lp_diff = ACC_W'($signed(spk[ch])) * ACC_W'(32768) - lp[ch];
  assign env_mag = lp[ch][ACC_W-1] ? -lp[ch] : lp[ch];
  assign env_diff = env_mag - env[ch];
  assign mix_sum = hn + t_val;
  assign mix_mag = mix_sum[ACC_W-1] ? -mix_sum : mix_sum;
  assign gen_abs = t_val[ACC_W-1] ? -t_val : t_val;

  // Gained product t * percent * gain fits in 80 bits; take magnitude.
  logic [79:0] gain_abs;
  assign gain_abs = mul_prod[79] ? 80'(-mul_prod) : 80'(mul_prod);

  // The finished sample moves to the output register once it is empty or being taken.
  assign out_free = !out_valid || out_ch.ready;

  assign in_ch.ready = (state == ST_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.haptic_out_left = res[0];
  assign out_ch.haptic_out_right = res[1];

  always_comb begin
    state_next = state;
    mul_start = 1'b0;
    mul_a = '0;
    mul_b = '0;
    div_start = 1'b0;
    div_num = '0;
    div_den = '0;
    unique case (state)
      ST_IDLE: begin
        // With the generator off, the output is the scaled native signal.
        if (in_ch.valid && in_ch.ready)
          state_next = (gen_mode == MODE_OFF) ? ST_OUT : ST_LP;
      end
      ST_LP: begin
        mul_a = lp_diff;
        mul_b = lowpass_coef(lowpass_select);
        mul_start = !started;
        if (mul_done) state_next = ST_ENV;
      end
      ST_ENV: begin
        mul_a = env_diff;
        mul_b = (env_mag > env[ch]) ? ATTACK_Q30 : RELEASE_Q30;
        mul_start = !started;
        if (mul_done) state_next = ST_SHAPE;
      end
      ST_SHAPE: begin
        mul_a = lp[ch];
        mul_b = 32'(ONE_Q30 + 3 * env[ch]);
        mul_start = !started;
        if (mul_done) state_next = ST_GAIN;
      end
      ST_GAIN: begin
        mul_a = t_val;
        mul_b = 32'(auto_gain_percent) * 32'(haptic_gain);
        mul_start = !started;
        if (mul_done) state_next = ST_GDIV;
      end
      ST_GDIV: begin
        div_num = 64'(gain_abs + 80'd204800);
        div_den = 64'(GAIN_DIV);
        div_start = !started;
        if (div_done) state_next = ST_CLIP;
      end
      ST_CLIP: begin
        div_num = 64'h1000_0000_0000_0000 + ((64'(1 << 30) + 64'(gen_abs)) >> 1);
        div_den = 64'(1 << 30) + 64'(gen_abs);
        div_start = !started;
        if (div_done)
          state_next = (gen_mode == MODE_MIX) ? ST_MIXCLIP : ST_NEXTCH;
      end
      ST_MIXCLIP: begin
        div_num = 64'h1000_0000_0000_0000 + ((64'(1 << 30) + 64'(mix_mag)) >> 1);
        div_den = 64'(1 << 30) + 64'(mix_mag);
        div_start = !started;
        if (div_done) state_next = ST_NEXTCH;
      end
      ST_NEXTCH: state_next = ch ? ST_OUT : ST_LP;
      ST_OUT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  logic [15:0] abs_l, abs_r, pk;
  assign abs_l = in_ch.native_left[15] ? 16'(-in_ch.native_left) : in_ch.native_left;
  assign abs_r = in_ch.native_right[15] ? 16'(-in_ch.native_right) : in_ch.native_right;
  always_comb begin
    pk = packet_peak;
    if (abs_l > pk) pk = abs_l;
    if (abs_r > pk) pk = abs_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      started <= 1'b0;
      ch <= 1'b0;
      lp[0] <= '0; lp[1] <= '0;
      env[0] <= '0; env[1] <= '0;
      silence_count <= SIL_MAX;
      packet_peak <= '0;
      fallback_flag <= 1'b1;
    end else begin
      started <= (state_next == state) && (state != ST_IDLE);
      if (state == ST_IDLE && in_ch.valid && in_ch.ready) begin
        spk[0] <= in_ch.speaker_left;
        spk[1] <= in_ch.speaker_right;
        nat[0] <= in_ch.native_left;
        nat[1] <= in_ch.native_right;
        pend <= in_ch.packet_end;
        ch <= 1'b0;
        use_gen <= (gen_mode == MODE_REPLACE) ||
                   (gen_mode == MODE_FALLBACK && fallback_flag);
        if (in_ch.packet_end) begin
          packet_peak <= '0;
          if (pk > 16'(QUIET_PEAK)) silence_count <= '0;
          else if (silence_count < SIL_MAX) silence_count <= silence_count + 1'b1;
        end else begin
          packet_peak <= pk;
        end
      end
      if (state == ST_LP && mul_done) lp[ch] <= lp[ch] + ACC_W'(mul_rnd);
      if (state == ST_ENV && mul_done) env[ch] <= env[ch] + ACC_W'(mul_rnd);
      if (state == ST_SHAPE && mul_done) t_val <= ACC_W'(mul_rnd);
      if (state == ST_GAIN && mul_done) neg <= mul_prod[79];
      if (state == ST_GDIV && div_done)
        t_val <= neg ? -ACC_W'(div_q) : ACC_W'(div_q);
      if (state == ST_CLIP && div_done) begin
        g_val <= t_val[ACC_W-1] ? ACC_W'(div_q) - ONE_Q30 : ONE_Q30 - ACC_W'(div_q);
        t_val <= t_val[ACC_W-1] ? ACC_W'(div_q) - ONE_Q30 : ONE_Q30 - ACC_W'(div_q);
      end
      if (state == ST_MIXCLIP && div_done)
        g_val <= mix_sum[ACC_W-1] ? ACC_W'(div_q) - ONE_Q30 : ONE_Q30 - ACC_W'(div_q);
      if (state == ST_NEXTCH) begin
        work_res[ch] <= (use_gen || gen_mode == MODE_MIX) ? to_q15(g_val) : to_q15(hn);
        ch <= 1'b1;
      end
      if (state == ST_OUT && out_free) begin
        if (gen_mode == MODE_OFF) begin
          res[0] <= to_q15(ACC_W'($signed(nat[0]) * $signed({1'b0, haptic_gain})) <<< 3);
          res[1] <= to_q15(ACC_W'($signed(nat[1]) * $signed({1'b0, haptic_gain})) <<< 3);
        end else begin
          res[0] <= work_res[0];
          res[1] <= work_res[1];
        end
        out_valid <= 1'b1;
        fallback_flag <= pend ? (silence_count >= SIL_TO) : fallback_flag;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

### bench/testbench.sv
// testbench: self-checking bench for audio_to_haptics_generator.
// Depends on athg_pkg, athg_if and the RTL. Drives random four-channel samples through
// several register settings and checks every haptic result against a bit-exact predictor.
`timescale 1ns / 1ps
module testbench;
  import athg_pkg::*;

  localparam int SILENCE_LIMIT = 100;
  localparam longint CYCLE_LIMIT = 20000000;
  localparam int PHASE_ITEMS = 150;
  localparam longint Q30 = 64'sd1 << 30;

  typedef struct packed {
    logic signed [15:0] spk_l;
    logic signed [15:0] spk_r;
    logic signed [15:0] nat_l;
    logic signed [15:0] nat_r;
    logic pkt_end;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } drive_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  athg_in_if in_ch ();
  athg_out_if out_ch ();

  audio_to_haptics_generator #(.SILENCE_TIMEOUT(SILENCE_LIMIT)) dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // The clock runs with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Register copies that the predictor uses. They change only while the block is idle.
  mode_t mode_cfg = MODE_FALLBACK;
  logic [15:0] native_gain = 16'd4096;
  logic [7:0] gen_percent = 8'd100;
  logic [1:0] lp_sel = 2'd0;

  // Predictor state, mirroring the filters, envelopes and silence tracking of the block.
  longint lp_l, lp_r, env_l, env_r;
  int unsigned silent_packets = 2 * SILENCE_LIMIT;
  int unsigned peak_in_packet = 0;
  bit fallback_on = 1'b1;
  int fallback_changes = 0;

  sample_t pending_samples[$];
  drive_t expected_drive[$];
  int errors = 0;
  int issued = 0;
  int accepted = 0;
  int checked = 0;
  longint cycles = 0;
  bit calm = 1'b0;
  logic stall_hold = 1'b0;

  task automatic report(input string msg);
    $display("ERROR at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // Round a Q value to fewer fraction bits: add one half, then take the floor.
  function automatic longint round_shift(input longint v, input int s);
    return (v + (64'sd1 << (s - 1))) >>> s;
  endfunction

  function automatic longint q30_mul(input longint a, input longint b);
    return round_shift(a * b, 30);
  endfunction

  function automatic longint abs_q(input longint v);
    return v < 0 ? -v : v;
  endfunction

  // Soft clip x/(1+|x|), written as 1 - 1/(1+|x|) with a rounded reciprocal.
  function automatic longint soft_limit(input longint x);
    longint unsigned den;
    longint unsigned quo;
    longint r;
    den = longint'(Q30) + abs_q(x);
    quo = ((64'd1 << 60) + den / 2) / den;
    r = Q30 - longint'(quo);
    return x < 0 ? -r : r;
  endfunction

  function automatic longint shape_channel(input longint spk, inout longint lp,
                                           inout longint env);
    longint coef, mag, shaped, num, gain;
    longint unsigned scaled;
    case (lp_sel)
      2'd0: coef = 11156178;
      2'd1: coef = 22269405;
      2'd2: coef = 33232309;
      default: coef = 55007794;
    endcase
    lp += q30_mul(coef, spk - lp);
    mag = abs_q(lp);
    // Fast attack when the level rises, slow release when it falls.
    if (mag > env) env += q30_mul(429496730, mag - env);
    else env += q30_mul(26843546, mag - env);
    shaped = q30_mul(lp, Q30 + 3 * env);
    gain = longint'(gen_percent) * longint'(native_gain);
    num = shaped * gain;
    scaled = (longint'(abs_q(num)) + 204800) / 409600;
    num = num < 0 ? -longint'(scaled) : longint'(scaled);
    return soft_limit(num);
  endfunction

  function automatic logic signed [15:0] to_sample(input longint v);
    longint r;
    if (v > Q30) v = Q30;
    if (v < -Q30) v = -Q30;
    r = round_shift(v, 15);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic void predict_haptics(input sample_t s);
    longint hl, hr, gl, gr;
    drive_t d;
    int unsigned pk;
    hl = longint'(s.nat_l) * longint'(native_gain) * 8;
    hr = longint'(s.nat_r) * longint'(native_gain) * 8;
    pk = 32'(abs_q(s.nat_l));
    if (pk > peak_in_packet) peak_in_packet = pk;
    pk = 32'(abs_q(s.nat_r));
    if (pk > peak_in_packet) peak_in_packet = pk;
    if (mode_cfg != MODE_OFF) begin
      gl = shape_channel(longint'(s.spk_l) * 32768, lp_l, env_l);
      gr = shape_channel(longint'(s.spk_r) * 32768, lp_r, env_r);
      if (mode_cfg == MODE_REPLACE || (mode_cfg == MODE_FALLBACK && fallback_on)) begin
        hl = gl;
        hr = gr;
      end else if (mode_cfg == MODE_MIX) begin
        hl = soft_limit(hl + gl);
        hr = soft_limit(hr + gr);
      end
    end
    d.left = to_sample(hl);
    d.right = to_sample(hr);
    expected_drive.push_back(d);
    // The packet peak, including this sample, decides whether the native signal is silent.
    if (s.pkt_end) begin
      if (peak_in_packet > 256) silent_packets = 0;
      else if (silent_packets < 2 * SILENCE_LIMIT) silent_packets++;
      peak_in_packet = 0;
      if (fallback_on != (silent_packets >= SILENCE_LIMIT)) fallback_changes++;
      fallback_on = silent_packets >= SILENCE_LIMIT;
    end
  endfunction

  // Driver: offers queued samples, with a random pause after each transaction outside calm phases.
  sample_t held;
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.speaker_left <= '0;
      in_ch.speaker_right <= '0;
      in_ch.native_left <= '0;
      in_ch.native_right <= '0;
      in_ch.packet_end <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_haptics(held);
        accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          held = pending_samples.pop_front();
          issued++;
          in_ch.speaker_left <= held.spk_l;
          in_ch.speaker_right <= held.spk_r;
          in_ch.native_left <= held.nat_l;
          in_ch.native_right <= held.nat_r;
          in_ch.packet_end <= held.pkt_end;
          in_ch.valid <= 1'b1;
          send_gap = calm ? 0 : $urandom_range(0, 14);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes results with random stalls and compares them with the oldest expectation.
  int recv_wait = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_drive.size() == 0) begin
          report($sformatf("unexpected result %0d/%0d", out_ch.haptic_out_left,
                           out_ch.haptic_out_right));
        end else begin
          drive_t e;
          e = expected_drive.pop_front();
          if (out_ch.haptic_out_left !== e.left)
            report($sformatf("result %0d left: got %0d, expected %0d", checked,
                             out_ch.haptic_out_left, e.left));
          if (out_ch.haptic_out_right !== e.right)
            report($sformatf("result %0d right: got %0d, expected %0d", checked,
                             out_ch.haptic_out_right, e.right));
        end
        checked++;
        recv_wait = calm ? 0 : $urandom_range(0, 14);
      end
      if (stall_hold) begin
        out_ch.ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // A long receiver stall while the driver keeps offering, so the block backs up.
  initial begin
    wait (accepted >= 400);
    @(posedge clk) stall_hold <= 1'b1;
    repeat (3000) @(posedge clk);
    stall_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Register write; the predictor's copy is updated when the write is driven, before the block takes it.
  task automatic write_reg(input reg_index_t idx, input logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_AUTO_MODE: mode_cfg = mode_t'(value[1:0]);
      REG_HAPTIC_GAIN: native_gain = value;
      REG_AUTO_GAIN: gen_percent = value[7:0];
      default: lp_sel = value[1:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_speaker();
    case ($urandom_range(0, 2))
      0: return 16'($urandom());
      1: return $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
      default: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    endcase
  endfunction

  // Quiet native samples stay within the silence threshold, including its edges.
  function automatic logic signed [15:0] rand_native(input bit loud);
    if (!loud) return $signed(16'($urandom_range(0, 512))) - 16'sd256;
    return 16'($urandom());
  endfunction

  function automatic void push_packet(input bit loud, input int len);
    sample_t s;
    for (int i = 0; i < len; i++) begin
      s.spk_l = rand_speaker();
      s.spk_r = rand_speaker();
      s.nat_l = rand_native(loud && $urandom_range(0, 1));
      s.nat_r = rand_native(loud && $urandom_range(0, 1));
      if (loud && i == len - 1) s.nat_l = $urandom_range(0, 1) ? 16'sd257 : 16'sh8000;
      s.pkt_end = (i == len - 1);
      pending_samples.push_back(s);
    end
  endfunction

  task automatic wait_idle();
    while (pending_samples.size() != 0 || issued != accepted || expected_drive.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  int phase_mode[8] = '{1, 3, 0, 2, 1, 2, 3, 1};
  int phase_gain[8] = '{4096, 65535, 0, 4096, 8192, 65535, 1, 4096};
  int phase_pct[8] = '{100, 255, 0, 100, 50, 255, 1, 100};
  int phase_lp[8] = '{0, 3, 0, 1, 2, 3, 0, 1};

  initial begin
    sample_t s;
    int target;
    cfg_we <= 1'b0;
    cfg_index <= REG_AUTO_MODE;
    cfg_data <= '0;
    lp_l = 0;
    lp_r = 0;
    env_l = 0;
    env_r = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 8; p++) begin
      // The first phase runs on reset defaults; later phases rewrite every register.
      if (p > 0) begin
        wait_idle();
        write_reg(REG_AUTO_MODE, 16'(phase_mode[p]));
        write_reg(REG_HAPTIC_GAIN, 16'(phase_gain[p]));
        write_reg(REG_AUTO_GAIN, 16'(phase_pct[p]));
        write_reg(REG_LOWPASS_SEL, 16'(phase_lp[p]));
      end
      calm = (p % 3 == 1);
      // Directed extremes: full-scale speaker steps, extreme native values, the threshold.
      s = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 1'b0};
      pending_samples.push_back(s);
      s = '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1};
      pending_samples.push_back(s);
      s = '{16'sh0000, 16'shFFFF, 16'sd256, -16'sd256, 1'b1};
      pending_samples.push_back(s);
      s = '{16'sh0001, 16'sh0000, 16'sd257, 16'sd0, 1'b1};
      pending_samples.push_back(s);
      s = '{16'sh7FFF, 16'sh7FFF, 16'sd0, 16'sd0, 1'b0};
      pending_samples.push_back(s);
      target = pending_samples.size() + PHASE_ITEMS;
      // Loud bursts and silent stretches are mixed at random; the longer silent stretches can arm the fallback.
      while (pending_samples.size() < target) begin
        if ($urandom_range(0, 2) == 0) begin
          for (int k = $urandom_range(20, 130); k > 0; k--)
            push_packet(1'b0, $urandom_range(1, 2));
        end else begin
          for (int k = $urandom_range(1, 5); k > 0; k--)
            push_packet(1'b1, $urandom_range(1, 4));
        end
      end
    end

    wait_idle();
    repeat (100) @(posedge clk);
    $display("Run covered %0d samples and %0d results over 8 register settings,", accepted,
             checked);
    $display("all four modes, and %0d fallback switches.", fallback_changes);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
